[hw/rtl/qalu_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qalu_pkg
// Shared types and constants of the quaternion arithmetic unit.
// ----------------------------------------------------------------------------
package qalu_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 24;
  localparam int ACT_W          = 4;

  // Operation codes carried by each request.
  typedef enum logic [ACT_W-1:0] {
    ACT_ADD      = 4'd0,
    ACT_ADD_S    = 4'd1,
    ACT_SUB      = 4'd2,
    ACT_SUB_S    = 4'd3,
    ACT_S_SUB    = 4'd4,
    ACT_PROD     = 4'd5,
    ACT_SCALE    = 4'd6,
    ACT_NEG      = 4'd7,
    ACT_CONJ     = 4'd8,
    ACT_NORM     = 4'd9
  } action_t;

  // Operand selects of the add/subtract path in a lane.
  typedef enum logic [1:0] {
    SEL_ZERO = 2'd0,
    SEL_A    = 2'd1,
    SEL_B    = 2'd2,
    SEL_R    = 2'd3
  } lin_sel_t;

  // Per-lane decode of one request.
  typedef struct packed {
    logic       mul;
    logic [3:0] neg;
    logic       lin_sub;
    lin_sel_t   la_sel;
    lin_sel_t   lb_sel;
  } lane_ctl_t;

  // Negated terms of the Hamilton product, one bit per term, per component.
  function automatic logic [3:0] hamilton_neg(input logic [1:0] lane);
    logic [3:0] m;
    case (lane)
      2'd0:    m = 4'b1110;
      2'd1:    m = 4'b1000;
      2'd2:    m = 4'b0010;
      2'd3:    m = 4'b0100;
      default: m = 4'b0000;
    endcase
    return m;
  endfunction

endpackage

[hw/rtl/qalu_req_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qalu_req_if
// Request channel: action code, two quaternions and a scalar.
// ----------------------------------------------------------------------------
interface qalu_req_if #(
  parameter int DATA_WIDTH = qalu_pkg::DATA_WIDTH_DEF
);
  logic                         valid;
  logic                         ready;
  logic [qalu_pkg::ACT_W-1:0]   action;
  logic signed [DATA_WIDTH-1:0] first_w;
  logic signed [DATA_WIDTH-1:0] first_x;
  logic signed [DATA_WIDTH-1:0] first_y;
  logic signed [DATA_WIDTH-1:0] first_z;
  logic signed [DATA_WIDTH-1:0] second_w;
  logic signed [DATA_WIDTH-1:0] second_x;
  logic signed [DATA_WIDTH-1:0] second_y;
  logic signed [DATA_WIDTH-1:0] second_z;
  logic signed [DATA_WIDTH-1:0] scalar_value;

  modport source (
    output valid, action, first_w, first_x, first_y, first_z,
           second_w, second_x, second_y, second_z, scalar_value,
    input  ready
  );
  modport sink (
    input  valid, action, first_w, first_x, first_y, first_z,
           second_w, second_x, second_y, second_z, scalar_value,
    output ready
  );
endinterface

[hw/rtl/qalu_rsp_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qalu_rsp_if
// Result channel: result quaternion and saturation flag.
// ----------------------------------------------------------------------------
interface qalu_rsp_if #(
  parameter int DATA_WIDTH = qalu_pkg::DATA_WIDTH_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] result_w;
  logic signed [DATA_WIDTH-1:0] result_x;
  logic signed [DATA_WIDTH-1:0] result_y;
  logic signed [DATA_WIDTH-1:0] result_z;
  logic                         saturated;

  modport source (
    output valid, result_w, result_x, result_y, result_z, saturated,
    input  ready
  );
  modport sink (
    input  valid, result_w, result_x, result_y, result_z, saturated,
    output ready
  );
endinterface

[hw/rtl/qalu_lane.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qalu_lane
// One result component: four multipliers, a signed sum, an add/subtract
// path and saturation, in three register stages.
// ----------------------------------------------------------------------------
module qalu_lane #(
  parameter int DATA_WIDTH = qalu_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = qalu_pkg::FRAC_BITS_DEF,
  parameter int LANE       = 0
) (
  input  logic                                   clk,
  input  logic                                   ce,
  input  logic [qalu_pkg::ACT_W-1:0]             action,
  input  logic [3:0][DATA_WIDTH-1:0]             a,
  input  logic [3:0][DATA_WIDTH-1:0]             b,
  input  logic [DATA_WIDTH-1:0]                  r,
  output logic [DATA_WIDTH-1:0]                  res,
  output logic                                   sat,
  output logic [2*DATA_WIDTH+1:0]                sum_out
);
  import qalu_pkg::*;

  localparam int DW = DATA_WIDTH;
  localparam int SW = 2 * DATA_WIDTH + 2;
  localparam int LW = DATA_WIDTH + 2;
  localparam logic [1:0] LIDX = LANE[1:0];

  lane_ctl_t                   ctl;
  logic [3:0][DW-1:0]          ma;
  logic [3:0][DW-1:0]          mb;
  logic signed [LW-1:0]        la;
  logic signed [LW-1:0]        lb;

  logic [3:0][2*DW-1:0]        prod;
  logic signed [LW-1:0]        lin1;
  logic                        mul1;
  logic [3:0]                  neg1;

  logic signed [SW-1:0]        acc;
  logic signed [SW-1:0]        sum2;
  logic signed [LW-1:0]        lin2;
  logic                        mul2;

  logic signed [SW-1:0]        shifted;
  logic                        ovf_mul;
  logic                        ovf_lin;
  logic [DW-1:0]               res_next;
  logic                        sat_next;

  function automatic logic signed [LW-1:0] lin_pick(
    input lin_sel_t s, input logic [DW-1:0] av, input logic [DW-1:0] bv,
    input logic [DW-1:0] rv);
    logic signed [LW-1:0] v;
    case (s)
      SEL_A:   v = LW'($signed(av));
      SEL_B:   v = LW'($signed(bv));
      SEL_R:   v = LW'($signed(rv));
      default: v = '0;
    endcase
    return v;
  endfunction

  // Decode of the request for this component.
  always_comb begin
    ctl = '0;
    case (action_t'(action))
      ACT_ADD: begin
        ctl.la_sel = SEL_A; ctl.lb_sel = SEL_B;
      end
      ACT_ADD_S: begin
        ctl.la_sel = SEL_A; ctl.lb_sel = (LANE == 0) ? SEL_R : SEL_ZERO;
      end
      ACT_SUB: begin
        ctl.la_sel = SEL_A; ctl.lb_sel = SEL_B; ctl.lin_sub = 1'b1;
      end
      ACT_SUB_S: begin
        ctl.la_sel = SEL_A; ctl.lb_sel = (LANE == 0) ? SEL_R : SEL_ZERO;
        ctl.lin_sub = 1'b1;
      end
      ACT_S_SUB: begin
        ctl.la_sel = (LANE == 0) ? SEL_R : SEL_ZERO; ctl.lb_sel = SEL_A;
        ctl.lin_sub = 1'b1;
      end
      ACT_PROD: begin
        ctl.mul = 1'b1; ctl.neg = hamilton_neg(LIDX);
      end
      ACT_SCALE: begin
        ctl.mul = 1'b1;
      end
      ACT_NEG: begin
        ctl.lb_sel = SEL_A; ctl.lin_sub = 1'b1;
      end
      ACT_CONJ: begin
        if (LANE == 0) begin
          ctl.la_sel = SEL_A;
        end else begin
          ctl.lb_sel = SEL_A; ctl.lin_sub = 1'b1;
        end
      end
      default: ctl = '0;
    endcase
  end

  // Multiplier operand selection.
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      ma[j] = '0;
      mb[j] = '0;
      case (action_t'(action))
        ACT_PROD: begin
          ma[j] = a[j]; mb[j] = b[LIDX ^ 2'(j)];
        end
        ACT_SCALE: begin
          if (j == 0) begin
            ma[j] = r; mb[j] = a[LIDX];
          end
        end
        ACT_NORM: begin
          if (LANE == 0) begin
            ma[j] = a[j]; mb[j] = a[j];
          end
        end
        default: begin
          ma[j] = '0; mb[j] = '0;
        end
      endcase
    end
    la = lin_pick(ctl.la_sel, a[LIDX], b[LIDX], r);
    lb = lin_pick(ctl.lb_sel, a[LIDX], b[LIDX], r);
  end

  // Stage 1: products and the exact add/subtract.
  always_ff @(posedge clk) begin
    if (ce) begin
      for (int j = 0; j < 4; j++) begin
        prod[j] <= $signed(ma[j]) * $signed(mb[j]);
      end
      lin1 <= ctl.lin_sub ? (la - lb) : (la + lb);
      mul1 <= ctl.mul;
      neg1 <= ctl.neg;
    end
  end

  // Stage 2: signed sum of the four products.
  always_comb begin
    acc = '0;
    for (int j = 0; j < 4; j++) begin
      if (neg1[j]) acc = acc - SW'($signed(prod[j]));
      else         acc = acc + SW'($signed(prod[j]));
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      sum2 <= acc;
      lin2 <= lin1;
      mul2 <= mul1;
    end
  end

  // Stage 3: drop the extra fraction (floor) and saturate.
  always_comb begin
    shifted = sum2 >>> FRAC_BITS;
    ovf_mul = !((&shifted[SW-1:DW-1]) || !(|shifted[SW-1:DW-1]));
    ovf_lin = !((&lin2[LW-1:DW-1]) || !(|lin2[LW-1:DW-1]));
    if (mul2) begin
      sat_next = ovf_mul;
      if (ovf_mul) res_next = {shifted[SW-1], {(DW-1){!shifted[SW-1]}}};
      else         res_next = shifted[DW-1:0];
    end else begin
      sat_next = ovf_lin;
      if (ovf_lin) res_next = {lin2[LW-1], {(DW-1){!lin2[LW-1]}}};
      else         res_next = lin2[DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      res     <= res_next;
      sat     <= sat_next;
      sum_out <= sum2;
    end
  end

endmodule

[hw/rtl/qalu_sqrt.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qalu_sqrt
// Pipelined integer square root, one root bit per register stage.
// ----------------------------------------------------------------------------
module qalu_sqrt #(
  parameter int DATA_WIDTH = qalu_pkg::DATA_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    ce,
  input  logic [2*DATA_WIDTH+1:0] rad,
  output logic [DATA_WIDTH:0]     root
);
  import qalu_pkg::*;

  localparam int N  = DATA_WIDTH + 1;
  localparam int SW = 2 * DATA_WIDTH + 2;

  logic [SW-1:0] rem_q  [0:N];
  logic [N-1:0]  root_q [0:N];

  assign rem_q[0]  = rad;
  assign root_q[0] = '0;

  // Each stage tries one root bit, highest first.
  for (genvar s = 0; s < N; s++) begin : g_stage
    localparam int K = N - 1 - s;
    logic [SW-1:0] trial;
    logic          fits;

    always_comb begin
      trial = (SW'(root_q[s]) << (K + 1)) | (SW'(1) << (2 * K));
      fits  = (trial <= rem_q[s]);
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        rem_q[s+1]  <= fits ? (rem_q[s] - trial) : rem_q[s];
        root_q[s+1] <= fits ? (root_q[s] | (N'(1) << K)) : root_q[s];
      end
    end
  end

  assign root = root_q[N];

endmodule

[hw/rtl/quaternion_alu.sv]
`timescale 1ns / 1ps
// Throughput: one request per cycle; the whole pipeline advances together and
// holds only while a finished result waits at the output register.
// Depth is set by the square root unit, which resolves one root bit per stage.
// Reset clears the valid bits of every stage and the output; data is not reset.
// ----------------------------------------------------------------------------
// quaternion_alu
// Quaternion arithmetic unit: four component lanes, a square root pipeline
// for the norm, and a merge stage that forms the result and the flag.
// ----------------------------------------------------------------------------
module quaternion_alu #(
  parameter int DATA_WIDTH = qalu_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = qalu_pkg::FRAC_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  qalu_req_if.sink   req,
  qalu_rsp_if.source rsp
);
  import qalu_pkg::*;

  localparam int DW    = DATA_WIDTH;
  localparam int N     = DATA_WIDTH + 1;
  localparam int DEPTH = N + 3;

  logic                 ce;
  logic [3:0][DW-1:0]   a;
  logic [3:0][DW-1:0]   b;
  logic [3:0][DW-1:0]   lane_res;
  logic [3:0]           lane_sat;
  logic [2*DW+1:0]      lane_sum [0:3];
  logic [DW:0]          root;
  logic                 root_clip;

  logic [DEPTH-1:0]     vld;
  logic [DEPTH-1:0]     nrm;
  logic [3:0][DW-1:0]   dres [0:N];
  logic [3:0]           dsat [0:N];
  logic                 out_norm;

  // The pipeline moves unless the output holds an untaken result.
  assign ce        = !rsp.valid || rsp.ready;
  assign req.ready = ce;

  assign a = {req.first_z, req.first_y, req.first_x, req.first_w};
  assign b = {req.second_z, req.second_y, req.second_x, req.second_w};

  // Component lanes.
  for (genvar i = 0; i < 4; i++) begin : g_lane
    qalu_lane #(
      .DATA_WIDTH (DATA_WIDTH),
      .FRAC_BITS  (FRAC_BITS),
      .LANE       (i)
    ) u_lane (
      .clk     (clk),
      .ce      (ce),
      .action  (req.action),
      .a       (a),
      .b       (b),
      .r       (req.scalar_value),
      .res     (lane_res[i]),
      .sat     (lane_sat[i]),
      .sum_out (lane_sum[i])
    );
  end

  // Norm: square root of the sum of squares formed in the first lane.
  qalu_sqrt #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_sqrt (
    .clk  (clk),
    .ce   (ce),
    .rad  (lane_sum[0]),
    .root (root)
  );

  // A root with either of its two top bits set exceeds the signed range.
  assign root_clip = root[DW] || root[DW-1];

  // Valid and norm-select bits that follow each request.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (ce) begin
      vld <= {vld[DEPTH-2:0], req.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      nrm <= {nrm[DEPTH-2:0], (action_t'(req.action) == ACT_NORM)};
    end
  end

  // Lane results wait alongside the square root stages.
  assign dres[0] = lane_res;
  assign dsat[0] = lane_sat;

  for (genvar k = 0; k < N; k++) begin : g_delay
    always_ff @(posedge clk) begin
      if (ce) begin
        dres[k+1] <= dres[k];
        dsat[k+1] <= dsat[k];
      end
    end
  end

  // Merge stage and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (ce) begin
      rsp.valid <= vld[DEPTH-1];
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      out_norm <= nrm[DEPTH-1];
      if (nrm[DEPTH-1]) begin
        rsp.result_w  <= root_clip ? {1'b0, {(DW-1){1'b1}}} : root[DW-1:0];
        rsp.result_x  <= '0;
        rsp.result_y  <= '0;
        rsp.result_z  <= '0;
        rsp.saturated <= root_clip;
      end else begin
        rsp.result_w  <= dres[N][0];
        rsp.result_x  <= dres[N][1];
        rsp.result_y  <= dres[N][2];
        rsp.result_z  <= dres[N][3];
        rsp.saturated <= |dsat[N];
      end
    end
  end

  // A norm result carries only its real part.
  a_norm_zero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && out_norm |->
      rsp.result_x == '0 && rsp.result_y == '0 && rsp.result_z == '0)
    else $error("norm result has nonzero vector part");

  // A norm is never negative.
  a_norm_sign: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && out_norm |-> !rsp.result_w[DW-1])
    else $error("norm result is negative");

  // A clipped norm sits at the top of the range.
  a_norm_clip: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && out_norm && rsp.saturated |->
      rsp.result_w == {1'b0, {(DW-1){1'b1}}})
    else $error("saturated norm is not the maximum value");

endmodule

[tb/quaternion_alu_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_alu_checker
// Watches the request and result channels of the quaternion unit, computes
// the exact fixed point answer of every accepted request and compares each
// accepted result, field by field, with the oldest answer still outstanding.
// ----------------------------------------------------------------------------
module quaternion_alu_checker #(
  parameter int DATA_WIDTH = qalu_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = qalu_pkg::FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  qalu_req_if  req,
  qalu_rsp_if  rsp,
  output int   fail_count,
  output int   outstanding
);
  import qalu_pkg::*;

  typedef logic signed [DATA_WIDTH-1:0] val_t;
  typedef logic signed [127:0]          wide_t;

  typedef struct {
    val_t w;
    val_t x;
    val_t y;
    val_t z;
    logic sat;
  } quat_result_t;

  localparam wide_t VMAX = (wide_t'(1) <<< (DATA_WIDTH - 1)) - 1;
  localparam wide_t VMIN = -(wide_t'(1) <<< (DATA_WIDTH - 1));

  quat_result_t expected_results[$];

  // Clip an exact value to the signed field range and note any clipping.
  function automatic val_t clip_val(input wide_t v, inout logic sat);
    if (v > VMAX) begin
      sat = 1'b1;
      return val_t'(VMAX);
    end
    if (v < VMIN) begin
      sat = 1'b1;
      return val_t'(VMIN);
    end
    return val_t'(v);
  endfunction

  // Exact sum of four products at double fraction, floored, then clipped.
  function automatic val_t dot4(input wide_t a0, b0, a1, b1, a2, b2, a3, b3,
                                inout logic sat);
    wide_t s;
    s = a0 * b0 + a1 * b1 + a2 * b2 + a3 * b3;
    return clip_val(s >>> FRAC_BITS, sat);
  endfunction

  function automatic quat_result_t quat_compute(
      input logic [ACT_W-1:0] act, input val_t qw, qx, qy, qz,
      input val_t pw, px, py, pz, input val_t r);
    quat_result_t res;
    wide_t aw, ax, ay, az, bw, bx, by, bz, sr, sum, root, cand;
    logic sat;
    aw = qw; ax = qx; ay = qy; az = qz;
    bw = pw; bx = px; by = py; bz = pz;
    sr = r;
    sat = 1'b0;
    res.w = '0; res.x = '0; res.y = '0; res.z = '0;
    case (act)
      ACT_ADD: begin
        res.w = clip_val(aw + bw, sat); res.x = clip_val(ax + bx, sat);
        res.y = clip_val(ay + by, sat); res.z = clip_val(az + bz, sat);
      end
      ACT_ADD_S: begin
        res.w = clip_val(aw + sr, sat); res.x = qx; res.y = qy; res.z = qz;
      end
      ACT_SUB: begin
        res.w = clip_val(aw - bw, sat); res.x = clip_val(ax - bx, sat);
        res.y = clip_val(ay - by, sat); res.z = clip_val(az - bz, sat);
      end
      ACT_SUB_S: begin
        res.w = clip_val(aw - sr, sat); res.x = qx; res.y = qy; res.z = qz;
      end
      ACT_S_SUB: begin
        res.w = clip_val(sr - aw, sat); res.x = clip_val(-ax, sat);
        res.y = clip_val(-ay, sat); res.z = clip_val(-az, sat);
      end
      ACT_PROD: begin
        res.w = dot4(aw, bw, -ax, bx, -ay, by, -az, bz, sat);
        res.x = dot4(aw, bx, ax, bw, ay, bz, -az, by, sat);
        res.y = dot4(aw, by, -ax, bz, ay, bw, az, bx, sat);
        res.z = dot4(aw, bz, ax, by, -ay, bx, az, bw, sat);
      end
      ACT_SCALE: begin
        res.w = clip_val((sr * aw) >>> FRAC_BITS, sat);
        res.x = clip_val((sr * ax) >>> FRAC_BITS, sat);
        res.y = clip_val((sr * ay) >>> FRAC_BITS, sat);
        res.z = clip_val((sr * az) >>> FRAC_BITS, sat);
      end
      ACT_NEG: begin
        res.w = clip_val(-aw, sat); res.x = clip_val(-ax, sat);
        res.y = clip_val(-ay, sat); res.z = clip_val(-az, sat);
      end
      ACT_CONJ: begin
        res.w = qw; res.x = clip_val(-ax, sat);
        res.y = clip_val(-ay, sat); res.z = clip_val(-az, sat);
      end
      ACT_NORM: begin
        // Floor square root, one bit at a time from the top.
        sum = aw * aw + ax * ax + ay * ay + az * az;
        root = 0;
        for (int b = DATA_WIDTH + 1; b >= 0; b--) begin
          cand = root | (wide_t'(1) <<< b);
          if (cand * cand <= sum) root = cand;
        end
        res.w = clip_val(root, sat);
      end
      default: ;
    endcase
    res.sat = sat;
    return res;
  endfunction

  task automatic report(input string what, input logic [127:0] got, exp_v);
    $display("[%0t] mismatch on %s: got %h expected %h", $time, what, got, exp_v);
    fail_count++;
  endtask

  // Record each accepted request and check each accepted result.
  always @(posedge clk) begin
    quat_result_t e;
    if (rst) begin
      expected_results.delete();
    end else begin
      if (req.valid && req.ready) begin
        expected_results.push_back(quat_compute(req.action,
          req.first_w, req.first_x, req.first_y, req.first_z,
          req.second_w, req.second_x, req.second_y, req.second_z,
          req.scalar_value));
      end
      if (rsp.valid && rsp.ready) begin
        if (expected_results.size() == 0) begin
          report("unexpected result", rsp.result_w, 0);
        end else begin
          e = expected_results.pop_front();
          if (rsp.result_w !== e.w) report("result_w", rsp.result_w, e.w);
          if (rsp.result_x !== e.x) report("result_x", rsp.result_x, e.x);
          if (rsp.result_y !== e.y) report("result_y", rsp.result_y, e.y);
          if (rsp.result_z !== e.z) report("result_z", rsp.result_z, e.z);
          if (rsp.saturated !== e.sat) report("saturated", rsp.saturated, e.sat);
        end
      end
    end
    outstanding = expected_results.size();
  end

  initial begin
    fail_count = 0;
    outstanding = 0;
  end
endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives the quaternion unit with directed corner requests, then random
// requests under two patterns of stalls on both channels and one with none,
// and reports the verdict of the checker.
// ----------------------------------------------------------------------------
module tb;
  import qalu_pkg::*;

  localparam int DW           = DATA_WIDTH_DEF;
  localparam int RANDOM_COUNT = 500;
  localparam int CYCLE_LIMIT  = 400000;

  typedef logic signed [DW-1:0] val_t;

  localparam val_t VMAX = {1'b0, {(DW-1){1'b1}}};
  localparam val_t VMIN = {1'b1, {(DW-1){1'b0}}};
  localparam val_t ONE  = val_t'(1) <<< FRAC_BITS_DEF;

  logic clk;
  logic rst;
  int   fail_count;
  int   outstanding;
  int   cycle_count;
  int   send_idle_pct;
  int   recv_idle_pct;

  qalu_req_if #(.DATA_WIDTH(DW)) req ();
  qalu_rsp_if #(.DATA_WIDTH(DW)) rsp ();

  quaternion_alu i_dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  quaternion_alu_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .req         (req),
    .rsp         (rsp),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Receiver stalls at random.
  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
    end else begin
      rsp.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Random operand: modest values half the time so products stay in range,
  // with full range words and the extremes mixed in.
  function automatic val_t rand_val();
    case ($urandom_range(0, 9))
      0, 1, 2: return val_t'($urandom);
      3:       return VMAX;
      4:       return VMIN;
      5:       return val_t'($urandom_range(0, 3)) - 1;
      default: return val_t'($signed($urandom) >>> $urandom_range(4, 12));
    endcase
  endfunction

  // Send one request, idling first at random, and wait for acceptance.
  task automatic send(input logic [ACT_W-1:0] act, input val_t qw, qx, qy, qz,
                      input val_t pw, px, py, pz, input val_t r);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid        <= 1'b1;
    req.action       <= act;
    req.first_w      <= qw;
    req.first_x      <= qx;
    req.first_y      <= qy;
    req.first_z      <= qz;
    req.second_w     <= pw;
    req.second_x     <= px;
    req.second_y     <= py;
    req.second_z     <= pz;
    req.scalar_value <= r;
    do @(posedge clk); while (!req.ready);
  endtask

  task automatic send_random(input int count);
    for (int n = 0; n < count; n++) begin
      send(ACT_W'($urandom_range(0, 15)), rand_val(), rand_val(), rand_val(),
           rand_val(), rand_val(), rand_val(), rand_val(), rand_val(), rand_val());
    end
  endtask

  initial begin
    cycle_count   = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    rst           = 1'b1;
    req.valid     = 1'b0;
    req.action    = '0;
    req.first_w   = '0;
    req.first_x   = '0;
    req.first_y   = '0;
    req.first_z   = '0;
    req.second_w  = '0;
    req.second_x  = '0;
    req.second_y  = '0;
    req.second_z  = '0;
    req.scalar_value = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed corners: each operation at the field extremes.
    send(ACT_ADD, VMAX, VMIN, 0, ONE, VMAX, VMIN, 0, -ONE, 0);
    send(ACT_ADD, VMIN, VMAX, -1, 1, 1, -1, 1, -1, 0);
    send(ACT_ADD_S, VMAX, VMIN, VMAX, VMIN, 0, 0, 0, 0, VMAX);
    send(ACT_ADD_S, VMIN, 1, 2, 3, 0, 0, 0, 0, VMIN);
    send(ACT_SUB, VMAX, VMIN, ONE, 0, VMIN, VMAX, ONE, 0, 0);
    send(ACT_SUB_S, VMIN, VMAX, VMIN, VMAX, 0, 0, 0, 0, VMAX);
    send(ACT_SUB_S, ONE, 5, 6, 7, 0, 0, 0, 0, VMIN);
    send(ACT_S_SUB, VMIN, VMIN, VMAX, 0, 0, 0, 0, 0, VMAX);
    send(ACT_S_SUB, VMAX, 1, -1, VMIN, 0, 0, 0, 0, VMIN);
    send(ACT_PROD, ONE, ONE, ONE, ONE, ONE, -ONE, ONE, -ONE, 0);
    send(ACT_PROD, VMAX, VMAX, VMAX, VMAX, VMAX, VMAX, VMAX, VMAX, 0);
    send(ACT_PROD, VMIN, VMIN, VMIN, VMIN, VMIN, VMAX, VMIN, VMAX, 0);
    send(ACT_PROD, -1, 1, -1, 1, 1, 1, -1, -1, 0);
    send(ACT_SCALE, VMAX, VMIN, -1, 1, 0, 0, 0, 0, VMIN);
    send(ACT_SCALE, ONE, -ONE, 3, -3, 0, 0, 0, 0, -1);
    send(ACT_SCALE, VMAX, VMIN, ONE, -ONE, 0, 0, 0, 0, VMAX);
    send(ACT_NEG, VMIN, VMAX, 0, -1, 0, 0, 0, 0, 0);
    send(ACT_CONJ, VMIN, VMIN, VMAX, 0, 0, 0, 0, 0, 0);
    send(ACT_NORM, VMIN, VMIN, VMIN, VMIN, 0, 0, 0, 0, 0);
    send(ACT_NORM, VMAX, 0, 0, 0, 0, 0, 0, 0, 0);
    send(ACT_NORM, 3 * ONE, 4 * ONE, 0, 0, 0, 0, 0, 0, 0);
    send(ACT_NORM, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    send(4'd10, VMAX, VMIN, 1, 1, 1, 1, 1, 1, 1);
    send(4'd15, -1, -1, -1, -1, -1, -1, -1, -1, -1);

    // Random requests under two stall patterns, then with no stalls.
    send_idle_pct = 32;
    recv_idle_pct = 74;
    send_random(RANDOM_COUNT);
    send_idle_pct = 74;
    recv_idle_pct = 32;
    send_random(RANDOM_COUNT);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_random(RANDOM_COUNT);
    req.valid <= 1'b0;

    // Drain, then allow for the pipeline depth.
    while (outstanding != 0) @(posedge clk);
    repeat (2 * DW + 20) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
